### hw/rtl/fwsb_pkg.sv
// shared types and constants for the frame window sequence buffer
package fwsb_pkg;

  // raw word width and packed point width (x, y, z, doppler, power)
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 5;
  localparam int DATA_W     = WORD_W * NUM_WORDS;

  // action code width on the input tuser
  localparam int ACT_W      = 2;

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // input item action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_END   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LENGTH       = 2'd0,
    CFG_POINTS_PER_FRAME = 2'd1,
    CFG_EMIT_STRIDE      = 2'd2,
    CFG_EARLY_MINIMUM    = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic [3:0] SEQ_LENGTH_RST       = 4'd8;
  localparam logic [3:0] POINTS_PER_FRAME_RST = 4'd8;
  localparam logic [7:0] EMIT_STRIDE_RST      = 8'd1;
  localparam logic [3:0] EARLY_MINIMUM_RST    = 4'd0;

endpackage

### hw/rtl/frame_window_sequence_buffer_unit.sv
// frame ring buffer that emits strided windows of points from block memory
// start: after an end-of-frame item is accepted, the state register moves to emit, then the
//   first window point is read into the output register and m_tvalid rises
// throughput: one input item per cycle; a window streams len*ppf points at one per cycle
//   when m_tready allows (one point memory read each) and blocks input until the last read
// reset: rst clears control state and registers to their defaults; point and count memories
//   are not cleared, there is no clearing pass after reset
module frame_window_sequence_buffer_unit #(
  parameter int WINDOW_CAPACITY = 8,
  parameter int POINT_CAPACITY  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [fwsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwsb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // x_pos, y_pos, z_pos, doppler_word, power_word
  input  logic [fwsb_pkg::DATA_W-1:0]       s_tdata,
  // action
  input  logic [fwsb_pkg::ACT_W-1:0]        s_tuser,
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_x, out_y, out_z, out_doppler, out_power
  output logic [fwsb_pkg::DATA_W-1:0]       m_tdata,
  // window_last
  output logic                              m_tlast
);
  import fwsb_pkg::*;

  localparam int FW    = $clog2(WINDOW_CAPACITY + 1);
  localparam int SW    = (WINDOW_CAPACITY > 1) ? $clog2(WINDOW_CAPACITY) : 1;
  localparam int CW    = $clog2(POINT_CAPACITY + 1);
  localparam int DEPTH = WINDOW_CAPACITY * POINT_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  // ring slot plus offset, offset never beyond one wrap
  function automatic logic [SW-1:0] slot_add(logic [SW-1:0] base, logic [FW-1:0] off);
    int sum;
    sum = int'(base) + int'(off);
    if (sum >= WINDOW_CAPACITY) sum = sum - WINDOW_CAPACITY;
    return SW'(sum);
  endfunction

  // registers
  state_t          state;
  logic [3:0]      seq_length;
  logic [3:0]      points_per_frame;
  logic [7:0]      emit_stride;
  logic [3:0]      early_minimum;
  logic [SW-1:0]   oldest_slot;
  logic [FW-1:0]   frames_held;
  logic [7:0]      stride_phase;
  logic [CW-1:0]   points_in_frame;
  logic [FW-1:0]   frame_idx;
  logic [CW-1:0]   point_idx;
  logic [FW-1:0]   pad;
  logic            out_valid;
  logic            rd_last;
  logic [CW-1:0]   rd_point;
  logic [DATA_W-1:0] rd_data;
  logic [CW-1:0]   rd_count;

  // memories
  logic [DATA_W-1:0] point_mem [DEPTH];
  logic [CW-1:0]     count_mem [WINDOW_CAPACITY];

  // combinational
  logic [FW-1:0]   len;
  logic [CW-1:0]   ppf;
  logic [7:0]      stride;
  logic [SW-1:0]   wslot;
  logic            accept;
  action_t         act;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            commit;
  logic [FW-1:0]   held_kept;
  logic [FW-1:0]   held_next;
  logic [SW-1:0]   oldest_next;
  logic [8:0]      phase_inc;
  logic [7:0]      phase_next;
  logic            full;
  logic            match;
  logic            early;
  logic            start_emit;
  logic [FW-1:0]   pad_next;
  logic [SW-1:0]   e_slot;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic            e_last;

  // clamped configuration
  always_comb begin
    if (seq_length == '0) begin
      len = FW'(1);
    end else if (int'(seq_length) > WINDOW_CAPACITY) begin
      len = FW'(WINDOW_CAPACITY);
    end else begin
      len = FW'(seq_length);
    end
    if (points_per_frame == '0) begin
      ppf = CW'(1);
    end else if (int'(points_per_frame) > POINT_CAPACITY) begin
      ppf = CW'(POINT_CAPACITY);
    end else begin
      ppf = CW'(points_per_frame);
    end
    stride = (emit_stride == '0) ? 8'd1 : emit_stride;
  end

  // input side decode and point write
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign act      = action_t'(s_tuser);
  assign wslot    = slot_add(oldest_slot, frames_held);
  assign wr_en    = accept && (act == ACT_ADD) && (points_in_frame < ppf);
  assign wr_addr  = AW'(int'(wslot) * POINT_CAPACITY + int'(points_in_frame));
  assign commit   = accept && (act == ACT_END);

  // commit: drop oldest frames, advance stride phase, decide on emission
  always_comb begin
    if (frames_held >= len) begin
      held_kept   = len - FW'(1);
      oldest_next = slot_add(oldest_slot, frames_held - len + FW'(1));
    end else begin
      held_kept   = frames_held;
      oldest_next = oldest_slot;
    end
    held_next  = held_kept + FW'(1);
    phase_inc  = {1'b0, stride_phase} + 9'd1;
    phase_next = (phase_inc >= {1'b0, stride}) ? 8'd0 : phase_inc[7:0];
    full       = (held_next == len);
    match      = (phase_next == 8'd0);
    early      = !full && match && (early_minimum != '0) &&
                 (int'(held_next) >= int'(early_minimum));
    start_emit = (full && match) || early;
    pad_next   = early ? (len - held_next) : '0;
  end

  // emission read address, padding repeats the oldest frame
  assign e_slot  = (frame_idx < pad) ? oldest_slot : slot_add(oldest_slot, frame_idx - pad);
  assign rd_addr = AW'(int'(e_slot) * POINT_CAPACITY + int'(point_idx));
  assign rd_en   = (state == ST_EMIT) && (!out_valid || m_tready);
  assign e_last  = (frame_idx == len - FW'(1)) && (point_idx == ppf - CW'(1));

  // point memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_mem[wr_addr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= point_mem[rd_addr];
    end
  end

  // per-slot point count memory
  always_ff @(posedge clk) begin
    if (commit) begin
      count_mem[wslot] <= points_in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_count <= count_mem[e_slot];
    end
  end

  // control state, configuration and output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_last  <= e_last;
      rd_point <= point_idx;
    end
    if (rst) begin
      state            <= ST_IDLE;
      seq_length       <= SEQ_LENGTH_RST;
      points_per_frame <= POINTS_PER_FRAME_RST;
      emit_stride      <= EMIT_STRIDE_RST;
      early_minimum    <= EARLY_MINIMUM_RST;
      oldest_slot      <= '0;
      frames_held      <= '0;
      stride_phase     <= '0;
      points_in_frame  <= '0;
      frame_idx        <= '0;
      point_idx        <= '0;
      pad              <= '0;
      out_valid        <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SEQ_LENGTH:       seq_length       <= cfg_data[3:0];
          CFG_POINTS_PER_FRAME: points_per_frame <= cfg_data[3:0];
          CFG_EMIT_STRIDE:      emit_stride      <= cfg_data;
          CFG_EARLY_MINIMUM:    early_minimum    <= cfg_data[3:0];
          default: ;
        endcase
      end

      // output valid follows reads and downstream acceptance
      if (rd_en) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_ADD: begin
                if (points_in_frame < ppf) begin
                  points_in_frame <= points_in_frame + CW'(1);
                end
              end
              ACT_END: begin
                points_in_frame <= '0;
                oldest_slot     <= oldest_next;
                frames_held     <= held_next;
                stride_phase    <= phase_next;
                if (start_emit) begin
                  state     <= ST_EMIT;
                  frame_idx <= '0;
                  point_idx <= '0;
                  pad       <= pad_next;
                end
              end
              ACT_CLEAR: begin
                oldest_slot     <= '0;
                frames_held     <= '0;
                stride_phase    <= '0;
                points_in_frame <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          // walk the window, one point per read
          if (rd_en) begin
            if (point_idx == ppf - CW'(1)) begin
              point_idx <= '0;
              if (frame_idx == len - FW'(1)) begin
                state <= ST_IDLE;
              end else begin
                frame_idx <= frame_idx + FW'(1);
              end
            end else begin
              point_idx <= point_idx + CW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // unfilled slots read as zero
  assign m_tvalid = out_valid;
  assign m_tdata  = (rd_point < rd_count) ? rd_data : '0;
  assign m_tlast  = rd_last;

endmodule

### hw/rtl/fwsb_checker.sv
// port-level checks for the frame window sequence buffer and their bind
module fwsb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [fwsb_pkg::ACT_W-1:0]    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fwsb_pkg::DATA_W-1:0]   m_tdata,
  input logic                          m_tlast
);
  import fwsb_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input is held off while a window is still being read out
  a_mid_window_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a window");

  // only an end-of-frame item can start a window
  a_no_emit_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != ACT_END) |=> s_tready)
    else $error("window started without end of frame");

endmodule

bind frame_window_sequence_buffer_unit fwsb_checker u_fwsb_checker (.*);
